FILE: rtl/msd_pkg.sv
// Package: shared constants and types of the multi-switch time debouncer.
`timescale 1ns / 1ps
package msd_pkg;

  localparam int SWITCH_COUNT_DEF = 26;
  localparam int TIME_BITS_DEF    = 32;

  localparam int NOW_W      = 32;
  localparam int INTERVAL_W = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = INTERVAL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT    = CFG_IDX_W'(1);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(20);
  localparam logic [COUNT_W-1:0]    COUNT_RST    = COUNT_W'(26);

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // Per-request command broadcast to every lane.
  typedef struct packed {
    logic                  load;
    logic                  init;
    logic [NOW_W-1:0]      now;
    logic [INTERVAL_W-1:0] interval;
  } msd_cmd_t;

endpackage

FILE: rtl/msd_lane.sv
// One switch lane: debounced bit and last accepted change time.
`timescale 1ns / 1ps
module msd_lane #(
  parameter int TIME_BITS = msd_pkg::TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msd_pkg::msd_cmd_t cmd_i,
  input  logic             raw_i,
  input  logic             active_i,
  output logic             bit_d_o
);
  import msd_pkg::*;

  localparam int CMP_W = (TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W;

  logic                 deb_q, deb_d;
  logic [TIME_BITS-1:0] ts_q, ts_d;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;

  assign elapsed = cmd_i.now[TIME_BITS-1:0] - ts_q;
  assign expired = CMP_W'(elapsed) >= CMP_W'(cmd_i.interval);

  always_comb begin
    deb_d = deb_q;
    ts_d  = ts_q;
    if (cmd_i.load) begin
      if (cmd_i.init) begin
        deb_d = raw_i & active_i;
      end else if (active_i && (raw_i != deb_q) && expired) begin
        deb_d = raw_i;
        ts_d  = cmd_i.now[TIME_BITS-1:0];
      end
    end
  end

  assign bit_d_o = deb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= 1'b0;
      ts_q  <= '0;
    end else begin
      deb_q <= deb_d;
      ts_q  <= ts_d;
    end
  end

endmodule

FILE: rtl/msd_merge.sv
// Merge stage: gathers lane bits into the registered result and runs the output handshake.
`timescale 1ns / 1ps
module msd_merge #(
  parameter int SWITCH_COUNT = msd_pkg::SWITCH_COUNT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [SWITCH_COUNT-1:0] lane_bits_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [SWITCH_COUNT-1:0] debounced_bits_o,
  output logic                    busy_o
);
  import msd_pkg::*;

  logic                    valid_q, valid_d;
  logic [SWITCH_COUNT-1:0] data_q;

  // Full and not draining: hold off new requests.
  assign busy_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= lane_bits_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign debounced_bits_o = data_q;

endmodule

FILE: rtl/multi_switch_time_debouncer_core.sv
// Top level: multi-switch time debouncer with per-switch lockout lanes.
// Result: a request accepted in one cycle shows its result, registered in the merge stage, in the next cycle.
// Throughput: one request per cycle unless a held result is stalled; every switch lane
// updates in the same cycle, set by one time subtract and interval compare per lane.
// Reset: debounced bits and timestamps clear to zero, interval 20 ms, 26 active switches.
`timescale 1ns / 1ps
module multi_switch_time_debouncer_core #(
  parameter int SWITCH_COUNT = msd_pkg::SWITCH_COUNT_DEF,
  parameter int TIME_BITS    = msd_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [SWITCH_COUNT-1:0]          pressed_bits_i,
  input  logic [msd_pkg::NOW_W-1:0]        now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [SWITCH_COUNT-1:0]          debounced_bits_o
);
  import msd_pkg::*;

  localparam int CNT_CMP_W = COUNT_W + 1;

  logic [INTERVAL_W-1:0]   interval_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    busy;
  logic                    accept;
  msd_cmd_t                cmd;
  logic [SWITCH_COUNT-1:0] active;
  logic [SWITCH_COUNT-1:0] raw;
  logic [SWITCH_COUNT-1:0] lane_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      count_q    <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_INTERVAL: interval_q <= cfg_wdata_i[INTERVAL_W-1:0];
        CFG_IDX_COUNT:    count_q    <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  assign cmd.load     = accept;
  assign cmd.init     = (op_i == OP_INIT);
  assign cmd.now      = now_ms_i;
  assign cmd.interval = interval_q;

  for (genvar i = 0; i < SWITCH_COUNT; i++) begin : g_lane
    assign active[i] = CNT_CMP_W'(i) < CNT_CMP_W'(count_q);
    assign raw[i]    = pressed_bits_i[i] & active[i];

    msd_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .raw_i   (raw[i]),
      .active_i(active[i]),
      .bit_d_o (lane_bits[i])
    );
  end

  msd_merge #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .lane_bits_i     (lane_bits),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .debounced_bits_o(debounced_bits_o),
    .busy_o          (busy)
  );

endmodule

FILE: rtl/msd_checker.sv
// Port-level checker for the multi-switch time debouncer, bound to the top level.
`timescale 1ns / 1ps
module msd_checker #(
  parameter int SWITCH_COUNT = msd_pkg::SWITCH_COUNT_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [SWITCH_COUNT-1:0] debounced_bits_o
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // Input only stalls behind a held result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Every accepted request yields a result next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no result after accepted request");

  // A taken result with no new request leaves the output empty.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !in_acc) |=> !out_valid_o)
    else $error("result repeated or invented");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(debounced_bits_o)))
    else $error("stalled result changed");

endmodule

bind multi_switch_time_debouncer_core msd_checker #(
  .SWITCH_COUNT(SWITCH_COUNT)
) u_msd_checker (.*);
